### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Property wrappers for the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint segment search package
// Widths, controller states and the command and status words shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CFG_W      = 7;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 17;
    localparam int QUO_W      = FRAC_W - 1;
    localparam int DIV_CNT_W  = $clog2(QUO_W);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_LAST  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        RD_FIRST = 2'd0,
        RD_LAST  = 2'd1,
        RD_NEXT  = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    query_start;
        t_rd_sel rd_sel;
        logic    save_prev;
        logic    scan_init;
        logic    scan_adv;
        logic    div_init;
        logic    div_step;
        logic    res_low;
        logic    res_high;
        logic    res_div;
    } t_cmd;

    typedef struct packed {
        logic le_first;
        logic ge_last;
        logic lt_cur;
        logic div_last;
    } t_sts;

endpackage

### rtl/bss_ctrl.sv
// ----------------------------------------------------------------------------
// Breakpoint segment search controller
// Takes load words; sequences the bound checks, scan and fraction division.
// ----------------------------------------------------------------------------
module bss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_mode,
    input  bss_pkg::t_sts i_sts,
    output bss_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import bss_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_FIRST;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode) begin
                        o_cmd.query_start = 1'b1;
                        n_state = S_FIRST;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_FIRST: begin
                if (i_sts.le_first) begin
                    o_cmd.res_low = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.save_prev = 1'b1;
                    o_cmd.rd_sel    = RD_LAST;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (i_sts.ge_last) begin
                    o_cmd.res_high = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    o_cmd.rd_sel    = RD_NEXT;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // The last breakpoint exceeds the value, so the scan always stops.
                if (i_sts.lt_cur) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.save_prev = 1'b1;
                    o_cmd.scan_adv  = 1'b1;
                    o_cmd.rd_sel    = RD_NEXT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    o_cmd.res_div = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

### rtl/bss_dp.sv
// ----------------------------------------------------------------------------
// Breakpoint segment search datapath
// Breakpoint memory, count register, scan registers and a restoring divider.
// ----------------------------------------------------------------------------
module bss_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bss_pkg::t_cmd                          i_cmd,
    input  logic                                   i_cfg_wr,
    input  logic [bss_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic [bss_pkg::IDX_W-1:0]              i_entry_index,
    input  logic signed [bss_pkg::DATA_W-1:0]      i_entry_value,
    input  logic signed [bss_pkg::DATA_W-1:0]      i_query_value,
    output bss_pkg::t_sts                          o_sts,
    output logic [bss_pkg::IDX_W-1:0]              o_segment_index,
    output logic [bss_pkg::FRAC_W-1:0]             o_fraction
);
    import bss_pkg::*;

    logic signed [DATA_W-1:0] r_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] r_rdata;
    logic        [CFG_W-1:0]  r_points;
    logic        [CNT_W-1:0]  r_n;
    logic        [CNT_W-1:0]  n_n;
    logic signed [DATA_W-1:0] r_v;
    logic signed [DATA_W-1:0] r_prev;
    logic        [IDX_W-1:0]  r_idx;
    logic        [IDX_W-1:0]  n_idx;
    logic        [IDX_W-1:0]  rd_addr;
    logic        [DATA_W-1:0] r_len;
    logic        [DATA_W-1:0] r_rem;
    logic        [QUO_W-1:0]  r_quo;
    logic        [DIV_CNT_W-1:0] r_div_cnt;
    logic        [IDX_W-1:0]  r_seg;
    logic        [FRAC_W-1:0] r_frac;
    logic        [DATA_W:0]   len_wide;
    logic        [DATA_W:0]   dif_wide;
    logic        [DATA_W:0]   rem_shift;
    logic        [DATA_W:0]   rem_sub;
    logic                     quo_bit;
    logic        [QUO_W-1:0]  n_quo;
    logic        [CNT_W-1:0]  n_last;
    logic        [CNT_W-1:0]  n_low;

    // Count in use, saturated to the range the table supports.
    always_comb begin
        priority if (CNT_W'(r_points) < CNT_W'(2)) begin
            n_n = CNT_W'(2);
        end else if (CNT_W'(r_points) > CNT_W'(MAX_POINTS)) begin
            n_n = CNT_W'(MAX_POINTS);
        end else begin
            n_n = CNT_W'(r_points);
        end
    end

    assign n_last = r_n - CNT_W'(1);
    assign n_low  = r_n - CNT_W'(2);

    always_comb begin
        priority if (i_cmd.scan_init) begin
            n_idx = IDX_W'(1);
        end else if (i_cmd.scan_adv) begin
            n_idx = r_idx + IDX_W'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = n_last[IDX_W-1:0];
            RD_NEXT:  rd_addr = n_idx;
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_entry_index] <= i_entry_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= CFG_W'(2);
        end else if (i_cfg_wr) begin
            r_points <= i_cfg_data;
        end
    end

    // Both differences are nonnegative inside the table, so 32 bits hold them.
    assign len_wide = {r_rdata[DATA_W-1], r_rdata} - {r_prev[DATA_W-1], r_prev};
    assign dif_wide = {r_v[DATA_W-1], r_v} - {r_prev[DATA_W-1], r_prev};

    // One restoring step: the remainder stays below the divisor throughout.
    assign rem_shift = {r_rem, 1'b0};
    assign rem_sub   = rem_shift - {1'b0, r_len};
    assign quo_bit   = (rem_shift >= {1'b0, r_len});
    assign n_quo     = {r_quo[QUO_W-2:0], quo_bit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_v <= i_query_value;
            r_n <= n_n;
        end
        if (i_cmd.save_prev) begin
            r_prev <= r_rdata;
        end
        r_idx <= n_idx;
        if (i_cmd.div_init) begin
            r_len     <= len_wide[DATA_W-1:0];
            r_rem     <= dif_wide[DATA_W-1:0];
            r_quo     <= '0;
            r_div_cnt <= '0;
            r_seg     <= r_idx - IDX_W'(1);
        end
        if (i_cmd.div_step) begin
            r_rem     <= quo_bit ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            r_quo     <= n_quo;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.res_div) begin
            r_frac <= {1'b0, n_quo};
        end
        if (i_cmd.res_low) begin
            r_seg  <= '0;
            r_frac <= '0;
        end
        if (i_cmd.res_high) begin
            r_seg  <= n_low[IDX_W-1:0];
            r_frac <= {1'b1, {QUO_W{1'b0}}};
        end
    end

    assign o_sts.le_first = (r_v <= r_rdata);
    assign o_sts.ge_last  = (r_v >= r_rdata);
    assign o_sts.lt_cur   = (r_v < r_rdata);
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(QUO_W - 1));

    assign o_segment_index = r_seg;
    assign o_fraction      = r_frac;

endmodule

### rtl/breakpoint_segment_search.sv
// ----------------------------------------------------------------------------
// Breakpoint segment search
// Locates a Q16.16 value in a loaded breakpoint table and returns the segment
// index and the Q1.16 interpolation fraction.
//
//   Channel   Direction  Handshake                    Payload
//   command   in         start high, busy low         mode, entry_index,
//                                                     entry_value, query_value
//   result    out        o_done strobe, one cycle     segment_index, fraction
//   config    in         i_cfg_valid, o_cfg_ready     points_in_use
//
// A load word is written in the cycle it is accepted; busy stays low.
// After a query word is accepted, busy stays high while the block checks the
// first breakpoint and, unless the value is at or below it, the last one.
// Unless the value is at or above the last, it then scans the entries from
// index 1 up to the first breakpoint above the value and runs the
// bit-serial divider over the 16 fraction bits. The result shows in the last
// busy cycle. Reset is synchronous, active low; the table contents survive it.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module breakpoint_segment_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [bss_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [bss_pkg::DATA_W-1:0] i_entry_value,
    input  logic signed [bss_pkg::DATA_W-1:0] i_query_value,
    output logic                              o_done,
    output logic [bss_pkg::IDX_W-1:0]         o_segment_index,
    output logic [bss_pkg::FRAC_W-1:0]        o_fraction,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bss_pkg::CFG_W-1:0]         i_cfg_data
);
    import bss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bss_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_wr        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_query_value   (i_query_value),
        .o_sts           (sts),
        .o_segment_index (o_segment_index),
        .o_fraction      (o_fraction)
    );

endmodule

### rtl/bss_checker.sv
// ----------------------------------------------------------------------------
// Breakpoint segment search checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_mode,
    input logic                              o_done,
    input logic [bss_pkg::FRAC_W-1:0]        o_fraction
);
    import bss_pkg::*;

    // A query word occupies the block; a load word does not.
    `ASSERT_NEXT(a_query_busy, start && !busy && i_mode, busy, "query did not raise busy")
    `ASSERT_NEXT(a_load_free, start && !busy && !i_mode, !busy, "load word held the block")
    // The result strobe comes in the last busy cycle of a query and does not repeat.
    `ASSERT_NEXT(a_done_single, o_done, !o_done && !busy, "result strobe repeated")
    `ASSERT_NOW(a_done_busy, o_done, busy, "result outside a query")
    // The fraction shown with a result never exceeds one.
    `ASSERT_NOW(a_frac_range, o_done, o_fraction <= FRAC_W'(65536), "fraction above one")

endmodule

bind breakpoint_segment_search bss_checker u_bss_checker (.*);
